[src/homography_point_warp_unit_macros.svh]
// ---------------------------------------------------------------------------
// Homography point warp: assertion macros
// Concurrent check forms for the files that assert.
// ---------------------------------------------------------------------------
`ifndef HOMOGRAPHY_POINT_WARP_UNIT_MACROS_SVH
`define HOMOGRAPHY_POINT_WARP_UNIT_MACROS_SVH

// same-cycle implication
`define HPW_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("hpw check failed");

// next-cycle implication
`define HPW_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hpw check failed");

`endif

[src/hpw_pkg.sv]
// ---------------------------------------------------------------------------
// Homography point warp: package
// Field widths, register indexes and shared types.
// ---------------------------------------------------------------------------
package hpw_pkg;

  localparam int FIELD_W = 32;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_PAIR_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAIR_B = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAIR_C = 3'd2;
  localparam logic [IDX_W-1:0] REG_PAIR_D = 3'd3;
  localparam logic [IDX_W-1:0] REG_LAST   = 3'd4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] c0;
    logic signed [FIELD_W-1:0] c1;
    logic signed [FIELD_W-1:0] c2;
  } coef_row_t;

endpackage

[src/hpw_point_if.sv]
// ---------------------------------------------------------------------------
// Homography point warp: channel interfaces
// Input point and warped result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface hpw_point_if import hpw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] point_x;
  logic signed [FIELD_W-1:0] point_y;
  logic signed [FIELD_W-1:0] point_w;

  modport source (output valid, output point_x, output point_y, output point_w,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_w,
                output ready);
endinterface

interface hpw_warp_if import hpw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] warped_x;
  logic signed [FIELD_W-1:0] warped_y;
  logic signed [FIELD_W-1:0] warped_w;
  logic                      at_infinity;
  logic                      saturated;

  modport source (output valid, output warped_x, output warped_y, output warped_w,
                  output at_infinity, output saturated, input ready);
  modport sink (input valid, input warped_x, input warped_y, input warped_w,
                input at_infinity, input saturated, output ready);
endinterface

[src/hpw_mac.sv]
// ---------------------------------------------------------------------------
// Homography point warp: matrix-vector stage
// Nine products, rounded row sums, clamp; three register stages.
// ---------------------------------------------------------------------------
module hpw_mac import hpw_pkg::*; #(
  parameter int COORD_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [FIELD_W-1:0]    px,
  input  logic signed [FIELD_W-1:0]    py,
  input  logic signed [FIELD_W-1:0]    pw,
  input  coef_row_t                    row_u,
  input  coef_row_t                    row_v,
  input  coef_row_t                    row_s,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] u,
  output logic signed [COORD_BITS-1:0] v,
  output logic signed [COORD_BITS-1:0] s,
  output logic                         sat
);

  localparam int PROD_W = 2 * FIELD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRACTION_BITS - 1);

  logic signed [PROD_W-1:0] prod [9];
  logic signed [SUM_W-1:0]  acc [3];
  logic                     vld1, vld2;
  logic                     rdy1, rdy2, rdy3;

  function automatic logic [COORD_BITS:0] clamp(input logic signed [SUM_W-1:0] x);
    logic hi_all;
    logic lo_all;
    hi_all = &x[SUM_W-1:COORD_BITS-1];
    lo_all = ~|x[SUM_W-1:COORD_BITS-1];
    if (hi_all || lo_all) begin
      return {1'b0, x[COORD_BITS-1:0]};
    end else if (x[SUM_W-1]) begin
      return {1'b1, 1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !vld2 || rdy3;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (rdy1) begin
      vld1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      prod[0] <= PROD_W'(px) * PROD_W'(row_u.c0);
      prod[1] <= PROD_W'(py) * PROD_W'(row_u.c1);
      prod[2] <= PROD_W'(pw) * PROD_W'(row_u.c2);
      prod[3] <= PROD_W'(px) * PROD_W'(row_v.c0);
      prod[4] <= PROD_W'(py) * PROD_W'(row_v.c1);
      prod[5] <= PROD_W'(pw) * PROD_W'(row_v.c2);
      prod[6] <= PROD_W'(px) * PROD_W'(row_s.c0);
      prod[7] <= PROD_W'(py) * PROD_W'(row_s.c1);
      prod[8] <= PROD_W'(pw) * PROD_W'(row_s.c2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (rdy2) begin
      vld2 <= vld1;
    end
    if (rdy2 && vld1) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= (SUM_W'(prod[3*k]) + SUM_W'(prod[3*k+1]) + SUM_W'(prod[3*k+2]) + HALF)
                  >>> FRACTION_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [COORD_BITS:0] cu, cv, cs;
    cu = clamp(acc[0]);
    cv = clamp(acc[1]);
    cs = clamp(acc[2]);
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= vld2;
    end
    if (rdy3 && vld2) begin
      u   <= cu[COORD_BITS-1:0];
      v   <= cv[COORD_BITS-1:0];
      s   <= cs[COORD_BITS-1:0];
      sat <= cu[COORD_BITS] | cv[COORD_BITS] | cs[COORD_BITS];
    end
  end

endmodule

[src/hpw_div.sv]
// ---------------------------------------------------------------------------
// Homography point warp: normalizing divider
// Two restoring dividers, one quotient bit per stage, round, sign, clamp.
// ---------------------------------------------------------------------------
module hpw_div import hpw_pkg::*; #(
  parameter int COORD_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] u,
  input  logic signed [COORD_BITS-1:0] v,
  input  logic signed [COORD_BITS-1:0] s,
  input  logic                         sat_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FIELD_W-1:0]    qx,
  output logic signed [FIELD_W-1:0]    qy,
  output logic signed [FIELD_W-1:0]    qw,
  output logic                         at_inf,
  output logic                         sat
);

  localparam int C = COORD_BITS;
  localparam int N = COORD_BITS + FRACTION_BITS;
  localparam logic [C+1:0] CAP2 = (C+2)'(1) << C;
  localparam logic [C:0]   CAP  = (C+1)'(1) << C;
  localparam logic [63:0]  ONE64 = (FRACTION_BITS >= C - 1) ?
                                   ((64'd1 << (C - 1)) - 64'd1) : (64'd1 << FRACTION_BITS);

  typedef struct packed {
    logic [C:0]          ru;
    logic [C:0]          rv;
    logic [C:0]          qu;
    logic [C:0]          qv;
    logic [C-1:0]        au;
    logic [C-1:0]        av;
    logic [C-1:0]        ad;
    logic                nu;
    logic                nv;
    logic                inf;
    logic                sat;
    logic signed [C-1:0] u;
    logic signed [C-1:0] v;
    logic signed [C-1:0] s;
  } lane_t;

  lane_t      st [N+1];
  logic [N:0] vld;
  logic [N+1:0] rdy;

  function automatic logic [2*C+1:0] div_step(input logic [C:0] r, input logic [C:0] q,
                                              input logic b, input logic [C-1:0] d);
    logic [C:0]   rs;
    logic [C+1:0] qs;
    logic         take;
    rs   = {r[C-1:0], b};
    take = rs >= {1'b0, d};
    if (take) begin
      rs = rs - {1'b0, d};
    end
    qs = {q, take};
    if (qs > CAP2) begin
      qs = CAP2;
    end
    return {rs, qs[C:0]};
  endfunction

  function automatic logic [C:0] finish(input logic [C:0] r, input logic [C:0] q,
                                        input logic [C-1:0] d, input logic n);
    logic [C:0]          qr;
    logic signed [C+1:0] res;
    qr = q;
    if (({1'b0, r} << 1) >= {2'b00, d} && q < CAP) begin
      qr = q + (C+1)'(1);
    end
    res = n ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    if (&res[C+1:C-1] || ~|res[C+1:C-1]) begin
      return {1'b0, res[C-1:0]};
    end else if (res[C+1]) begin
      return {1'b1, 1'b1, {(C-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(C-1){1'b1}}};
    end
  endfunction

  assign rdy[N+1]  = !out_valid || out_ready;
  assign in_ready  = rdy[0];

  genvar k;
  generate
    for (k = 0; k <= N; k++) begin : g_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      st[0].ru  <= '0;
      st[0].rv  <= '0;
      st[0].qu  <= '0;
      st[0].qv  <= '0;
      st[0].au  <= u[C-1] ? C'(-u) : C'(u);
      st[0].av  <= v[C-1] ? C'(-v) : C'(v);
      st[0].ad  <= s[C-1] ? C'(-s) : C'(s);
      st[0].nu  <= u[C-1] != s[C-1];
      st[0].nv  <= v[C-1] != s[C-1];
      st[0].inf <= s == '0;
      st[0].sat <= sat_in;
      st[0].u   <= u;
      st[0].v   <= v;
      st[0].s   <= s;
    end
  end

  generate
    for (k = 1; k <= N; k++) begin : g_stage
      lane_t        nxt;
      logic         bu, bv;
      logic [2*C+1:0] su, sv;
      if (k <= C) begin : g_bit
        assign bu = st[k-1].au[C-k];
        assign bv = st[k-1].av[C-k];
      end else begin : g_zero
        assign bu = 1'b0;
        assign bv = 1'b0;
      end
      always_comb begin
        su     = div_step(st[k-1].ru, st[k-1].qu, bu, st[k-1].ad);
        sv     = div_step(st[k-1].rv, st[k-1].qv, bv, st[k-1].ad);
        nxt    = st[k-1];
        nxt.ru = su[2*C+1:C+1];
        nxt.qu = su[C:0];
        nxt.rv = sv[2*C+1:C+1];
        nxt.qv = sv[C:0];
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
        if (rdy[k] && vld[k-1]) begin
          st[k] <= nxt;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    logic [C:0]         fu, fv;
    logic signed [63:0] ex, ey, ew;
    fu = finish(st[N].ru, st[N].qu, st[N].ad, st[N].nu);
    fv = finish(st[N].rv, st[N].qv, st[N].ad, st[N].nv);
    if (st[N].inf) begin
      ex = 64'(st[N].u);
      ey = 64'(st[N].v);
      ew = 64'(st[N].s);
    end else begin
      ex = 64'($signed(fu[C-1:0]));
      ey = 64'($signed(fv[C-1:0]));
      ew = $signed(ONE64);
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[N+1]) begin
      out_valid <= vld[N];
    end
    if (rdy[N+1] && vld[N]) begin
      qx     <= ex[FIELD_W-1:0];
      qy     <= ey[FIELD_W-1:0];
      qw     <= ew[FIELD_W-1:0];
      at_inf <= st[N].inf;
      sat    <= st[N].sat | (!st[N].inf & (fu[C] | fv[C]));
    end
  end

endmodule

[src/homography_point_warp_unit.sv]
// ---------------------------------------------------------------------------
// Homography point warp unit
// Pipeline: three multiply/sum stages, one divider setup stage, one stage
// per quotient bit, one round/clamp output register.
// Throughput: one point per cycle while the output is not stalled, which the per-bit divider pipeline allows.
// Reset: synchronous, clears valids and loads the identity matrix.
// ---------------------------------------------------------------------------
`include "homography_point_warp_unit_macros.svh"

module homography_point_warp_unit import hpw_pkg::*; #(
  parameter int COORD_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  hpw_point_if.sink        point,
  hpw_warp_if.source       warped,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data
);

  localparam logic [63:0] ONE64 = (FRACTION_BITS >= COORD_BITS - 1) ?
                                  ((64'd1 << (COORD_BITS - 1)) - 64'd1) :
                                  (64'd1 << FRACTION_BITS);

  logic [CFG_W-1:0]   pair_a, pair_b, pair_c, pair_d;
  logic [FIELD_W-1:0] coef_last;
  coef_row_t          row_u, row_v, row_s;

  logic                         m_valid, m_ready, m_sat;
  logic signed [COORD_BITS-1:0] m_u, m_v, m_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_a    <= 64'h0001_0000_0000_0000;
      pair_b    <= '0;
      pair_c    <= 64'h0001_0000_0000_0000;
      pair_d    <= '0;
      coef_last <= 32'h0001_0000;
    end else if (wr_en) begin
      case (wr_index)
        REG_PAIR_A: pair_a    <= wr_data;
        REG_PAIR_B: pair_b    <= wr_data;
        REG_PAIR_C: pair_c    <= wr_data;
        REG_PAIR_D: pair_d    <= wr_data;
        REG_LAST:   coef_last <= wr_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign row_u = '{c0: pair_a[63:32], c1: pair_a[31:0], c2: pair_b[63:32]};
  assign row_v = '{c0: pair_b[31:0],  c1: pair_c[63:32], c2: pair_c[31:0]};
  assign row_s = '{c0: pair_d[63:32], c1: pair_d[31:0], c2: coef_last};

  hpw_mac #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .px        (point.point_x),
    .py        (point.point_y),
    .pw        (point.point_w),
    .row_u     (row_u),
    .row_v     (row_v),
    .row_s     (row_s),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .u         (m_u),
    .v         (m_v),
    .s         (m_s),
    .sat       (m_sat)
  );

  hpw_div #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .u         (m_u),
    .v         (m_v),
    .s         (m_s),
    .sat_in    (m_sat),
    .out_valid (warped.valid),
    .out_ready (warped.ready),
    .qx        (warped.warped_x),
    .qy        (warped.warped_y),
    .qw        (warped.warped_w),
    .at_inf    (warped.at_infinity),
    .sat       (warped.saturated)
  );

  `HPW_ASSERT_IMP(a_inf_w_zero, clk, rst, warped.valid && warped.at_infinity, warped.warped_w == '0)
  `HPW_ASSERT_IMP(a_norm_w_one, clk, rst, warped.valid && !warped.at_infinity, warped.warped_w == ONE64[FIELD_W-1:0])
  `HPW_ASSERT_IMP(a_drained_ready, clk, rst, !warped.valid, point.ready)
  `HPW_ASSERT_NXT(a_mac_feeds_div, clk, rst, m_valid && m_ready, $past(m_valid))

endmodule

[dv/hpw_tb_if.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Homography point warp testbench: beat record types
// The block's channel interfaces live with the RTL; this file only groups
// the beat record types the bench uses for its expected-result store and directed table.
// ---------------------------------------------------------------------------
package hpw_tb_types_pkg;
  import hpw_pkg::*;

  typedef struct packed {
    logic signed [FIELD_W-1:0] wx;
    logic signed [FIELD_W-1:0] wy;
    logic signed [FIELD_W-1:0] ww;
    logic                      inf;
    logic                      sat;
  } warp_beat_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] px;
    logic signed [FIELD_W-1:0] py;
    logic signed [FIELD_W-1:0] pw;
    logic                      has_exp;
    warp_beat_t                exp_beat;
  } point_row_t;
endpackage

[dv/homography_point_warp_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Homography point warp unit testbench
// Streams homogeneous points through the block under several homographies,
// predicts each warped point in Q16.16 and checks every output beat in order.
// ---------------------------------------------------------------------------
module homography_point_warp_unit_tb;
  import hpw_pkg::*;
  import hpw_tb_types_pkg::*;

  localparam int LATENCY = 53;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0] wr_data = '0;

  hpw_point_if point ();
  hpw_warp_if  warped ();

  homography_point_warp_unit DUT (
    .clk(clk), .rst(rst), .point(point.sink), .warped(warped.source),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic signed [31:0] hm [0:2][0:2];
  warp_beat_t warp_queue[$];
  int errors = 0;
  int quiet_phase = 0;
  int hold_off = 0;
  bit src_idle = 0;

  initial begin
    point.valid = 1'b0;
    point.point_x = '0;
    point.point_y = '0;
    point.point_w = '0;
    warped.ready = 1'b0;
  end

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1; return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] project_row(logic signed [31:0] p[3], int r,
                                                     ref bit sat);
    logic signed [95:0] acc;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += 96'(p[i]) * 96'(hm[r][i]);
    acc = (acc + 96'sd32768) >>> 16;
    if (acc > 96'sd2147483647) begin
      sat = 1; return 64'sd2147483647;
    end
    if (acc < -96'sd2147483648) begin
      sat = 1; return -64'sd2147483648;
    end
    return 64'(acc);
  endfunction

  function automatic logic signed [63:0] fixed_div(logic signed [63:0] n,
                                                   logic signed [63:0] d, ref bit sat);
    logic [127:0] an, ad, q, rm;
    logic signed [63:0] res;
    an = n < 0 ? 128'(-n) : 128'(n);
    ad = d < 0 ? 128'(-d) : 128'(d);
    an = an << 16;
    q = an / ad;
    rm = an % ad;
    if (rm >= ad - rm) q++;
    if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
    res = 64'(q);
    if ((n < 0) != (d < 0)) res = -res;
    return clamp32(res, sat);
  endfunction

  function automatic warp_beat_t warp_point(logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] w);
    logic signed [31:0] p[3];
    logic signed [63:0] u, v, s;
    bit sat;
    warp_beat_t b;
    p[0] = x; p[1] = y; p[2] = w;
    sat = 0;
    u = project_row(p, 0, sat);
    v = project_row(p, 1, sat);
    s = project_row(p, 2, sat);
    if (s == 0) begin
      b.wx = u[31:0]; b.wy = v[31:0]; b.ww = '0; b.inf = 1'b1;
    end else begin
      b.wx = 32'(fixed_div(u, s, sat));
      b.wy = 32'(fixed_div(v, s, sat));
      b.ww = ONE; b.inf = 1'b0;
    end
    b.sat = sat;
    return b;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_PAIR_A: begin hm[0][0] = val[63:32]; hm[0][1] = val[31:0]; end
      REG_PAIR_B: begin hm[0][2] = val[63:32]; hm[1][0] = val[31:0]; end
      REG_PAIR_C: begin hm[1][1] = val[63:32]; hm[1][2] = val[31:0]; end
      REG_PAIR_D: begin hm[2][0] = val[63:32]; hm[2][1] = val[31:0]; end
      REG_LAST:   hm[2][2] = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_matrix(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                             logic [63:0] d, logic [31:0] e);
    write_reg(REG_PAIR_A, a);
    write_reg(REG_PAIR_B, b);
    write_reg(REG_PAIR_C, c);
    write_reg(REG_PAIR_D, d);
    write_reg(REG_LAST, {32'h0, e});
  endtask

  task automatic drain();
    point.valid <= 1'b0;
    while (warp_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] w);
    if (src_idle) begin
      point.valid <= 1'b0;
      while (src_idle) @(posedge clk);
    end
    point.valid <= 1'b1;
    point.point_x <= x; point.point_y <= y; point.point_w <= w;
    warp_queue.push_back(warp_point(x, y, w));
    @(posedge clk);
    while (!point.ready) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? MAXV : MINV;
      2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 32'($signed($urandom_range(0, 2048 << 16)) - (1024 << 16));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      2: return '0;
      default: return 32'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
    endcase
  endfunction

  // Idling bursts on both sides, none in the quiet phase
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        src_idle <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      src_idle <= 1'b0;
    end
  end

  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        warped.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 15);
        warped.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      warped.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    warp_beat_t e, a;
    if (!rst && warped.valid && warped.ready) begin
      a.wx = warped.warped_x; a.wy = warped.warped_y; a.ww = warped.warped_w;
      a.inf = warped.at_infinity; a.sat = warped.saturated;
      if (warp_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", a);
      end else begin
        e = warp_queue.pop_front();
        if (a !== e) begin
          errors++;
          if (errors <= 10)
            $display("mismatch x %h/%h y %h/%h w %h/%h inf %b/%b sat %b/%b",
                     e.wx, a.wx, e.wy, a.wy, e.ww, a.ww, e.inf, a.inf, e.sat, a.sat);
        end
      end
    end
  end

  point_row_t directed [] = '{
    '{32'sh00010000, 32'sh00020000, ONE, 1'b1, '{32'sh00010000, 32'sh00020000, ONE, 1'b0, 1'b0}},
    '{32'sh0, 32'sh0, ONE, 1'b1, '{32'sh0, 32'sh0, ONE, 1'b0, 1'b0}},
    '{32'sh00050000, 32'shfffd0000, 32'sh0, 1'b1, '{32'sh00050000, 32'shfffd0000, 32'sh0, 1'b1, 1'b0}},
    '{MAXV, MINV, ONE, 1'b1, '{MAXV, MINV, ONE, 1'b0, 1'b0}},
    '{MAXV, MAXV, MAXV, 1'b0, '0},
    '{MINV, MINV, MINV, 1'b0, '0},
    '{MAXV, MINV, 32'sh1, 1'b0, '0},
    '{32'sh00010000, 32'sh00010000, 32'sh2, 1'b0, '0},
    '{32'sh7, 32'shfffffff9, 32'sh00030000, 1'b0, '0},
    '{32'sh00018000, 32'shfffe8000, 32'shffff0000, 1'b0, '0},
    '{32'sh55555555, 32'shaaaaaaaa, 32'sh00008000, 1'b0, '0},
    '{32'sh1, 32'sh1, 32'sh8000, 1'b0, '0}
  };

  initial begin
    logic signed [31:0] m [9];
    hm = '{'{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].has_exp &&
          warp_point(directed[i].px, directed[i].py, directed[i].pw) !== directed[i].exp_beat) begin
        errors++;
        $display("directed row %0d predictor disagrees", i);
      end
      send_point(directed[i].px, directed[i].py, directed[i].pw);
    end
    drain();

    // extreme and degenerate matrices
    load_matrix({MAXV, MINV}, {MAXV, MINV}, {MINV, MAXV}, {MINV, MAXV}, MAXV);
    for (int i = 0; i < 8; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
    load_matrix({ONE, 32'h0}, {32'h0, 32'h0}, {ONE, 32'h0}, 64'h0, 32'h0);
    for (int i = 0; i < 6; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
    load_matrix(64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 64'hffffffff_ffffffff,
                64'hffffffff_ffffffff, 32'hffffffff);
    for (int i = 0; i < 6; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    // stall the output long enough to back up the pipeline
    hold_off = 300;
    for (int i = 0; i < 120; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 9; k++) m[k] = rand_coef();
      if (ph % 2 == 0) m[8] = ONE;
      load_matrix({m[0], m[1]}, {m[2], m[3]}, {m[4], m[5]}, {m[6], m[7]}, m[8]);
      if (ph == 7) quiet_phase = 1;
      for (int i = 0; i < 165; i++) begin
        if ($urandom_range(0, 9) == 0) send_point(rand_coord(), rand_coord(), 32'sh0);
        else send_point(rand_coord(), rand_coord(), $urandom_range(0, 3) == 0 ?
                        rand_coord() : ONE);
      end
      drain();
    end

    if (errors == 0) $display("[homography_point_warp_unit] OK");
    else $display("[homography_point_warp_unit] ERROR");
    $finish;
  end

  initial begin
    #3ms;
    $display("[homography_point_warp_unit] ERROR");
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/hpw_pkg.sv
src/hpw_point_if.sv
src/hpw_mac.sv
src/hpw_div.sv
src/homography_point_warp_unit.sv
dv/hpw_tb_if.sv
dv/homography_point_warp_unit_tb.sv
